// ----- rtl/rmts_pkg.sv -----
// Shared definitions for the rate-monotonic tick scheduler.
// Opcodes, field widths, stream widths and the slot unit's control struct.
// No dependencies.
`default_nettype none

package rmts_pkg;

    localparam int DEF_TASK_SLOTS = 16;
    localparam int DEF_TIME_WIDTH = 16;

    localparam int SLOT_W      = 4;
    localparam int FIELD_W     = 16;
    localparam int MISS_W      = 16;
    localparam int JOB_W       = 32;
    localparam int TICK_MISS_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BLOCK = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Control into the shared slot unit
    typedef struct packed {
        logic eligible;    // slot is active and not blocked
        logic best_valid;  // a candidate has been picked so far
        logic charge;      // this slot is the one picked on this tick
    } alu_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rmts_task_mem.sv -----
// Task table memory: one write port, one read port, registered read data.
// Depends on nothing; widths come from parameters.
`default_nettype none

module rmts_task_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 112
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rmts_slot_alu.sv -----
// Shared slot unit: period compare for the pick pass, and the budget charge,
// deadline countdown and counter updates for the update pass. Uses rmts_pkg.
`default_nettype none

module rmts_slot_alu
    import rmts_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  wire alu_ctl_t              ctl,
    input  wire logic [TIME_WIDTH-1:0] period,
    input  wire logic [TIME_WIDTH-1:0] capacity,
    input  wire logic [TIME_WIDTH-1:0] budget,
    input  wire logic [TIME_WIDTH-1:0] deadline,
    input  wire logic [TIME_WIDTH-1:0] best_period,
    input  wire logic [MISS_W-1:0]     miss,
    input  wire logic [JOB_W-1:0]      jobs,
    output logic                       better,
    output logic [TIME_WIDTH-1:0]      new_budget,
    output logic [TIME_WIDTH-1:0]      new_deadline,
    output logic [MISS_W-1:0]          new_miss,
    output logic [JOB_W-1:0]           new_jobs,
    output logic                       miss_hit
);

    logic [TIME_WIDTH-1:0] charged;
    logic                  expire;

    // strict compare keeps the lower slot on equal periods
    assign better = ctl.eligible && (budget != '0) &&
                    (!ctl.best_valid || (period < best_period));

    always_comb
    begin
        charged  = ctl.charge ? TIME_WIDTH'(budget - 1'b1) : budget;
        new_jobs = (ctl.charge && (jobs != '1)) ? JOB_W'(jobs + 1'b1) : jobs;
        expire   = (deadline <= TIME_WIDTH'(1));
        miss_hit = 1'b0;
        new_miss = miss;
        if (expire)
        begin
            miss_hit     = (charged != '0);
            new_deadline = period;
            new_budget   = capacity;
            if (miss_hit && (miss != '1))
            begin
                new_miss = MISS_W'(miss + 1'b1);
            end
        end
        else
        begin
            new_deadline = TIME_WIDTH'(deadline - 1'b1);
            new_budget   = charged;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rate_monotonic_tick_scheduler.sv -----
// Top level of the rate-monotonic tick scheduler: sequencer, flag vectors,
// output register. Uses rmts_pkg, rmts_task_mem and rmts_slot_alu.
//
//  channel | dir | tdata fields (low bit up)                     | tuser
//  --------+-----+-----------------------------------------------+-------
//  s_*     | in  | task_slot 4, period_value 16, capacity_value   | opcode 2
//          |     | 16, blocked_value 1, zero pad to 40            |
//  m_*     | out | selected_task 4, misses_this_tick 5,           | none
//          |     | slot_misses 16, slot_jobs 32, slot_budget_left |
//          |     | 16, slot_deadline_left 16, zero pad to 96      |
//
// A tick runs a pick sweep over slots 1..TASK_SLOTS-1, then an update sweep,
// both paced by the table's single read port. Load, set-blocked and read go
// through three steps in order: read, apply, push.
// Reset clears the sequencer, the active, blocked and written flags and the
// output valid; an unwritten entry reads as zero, so no clearing pass.
// A result waits in the output register; push stalls only while it is not taken.
`default_nettype none

module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // task_slot[3:0], period_value[19:4], capacity_value[35:20],
    // blocked_value[36], zero [39:37]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // selected_task[3:0], misses_this_tick[8:4], slot_misses[24:9],
    // slot_jobs[56:25], slot_budget_left[72:57], slot_deadline_left[88:73]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int SW    = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam int ENT_W = 4 * TIME_WIDTH + MISS_W + JOB_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
    localparam logic [IDX_W-1:0] SECOND_IDX = IDX_W'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PICK  = 3'd1;
    localparam logic [2:0] S_UPDT  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] period;
        logic [TIME_WIDTH-1:0] capacity;
        logic [TIME_WIDTH-1:0] budget;
        logic [TIME_WIDTH-1:0] deadline;
        logic [MISS_W-1:0]     miss;
        logic [JOB_W-1:0]      jobs;
    } ent_t;

    // input unpacking
    logic [1:0]            in_op;
    logic [SW-1:0]         in_slot;
    logic                  in_tab;
    logic [IDX_W-1:0]      in_idx;
    logic [TIME_WIDTH-1:0] in_per;
    logic [TIME_WIDTH-1:0] in_cap;
    logic                  s_accept;

    assign in_op    = s_tuser[1:0];
    assign in_slot  = SW'(s_tdata[3:0]);
    assign in_tab   = in_slot < SW'(TASK_SLOTS);
    assign in_idx   = in_slot[IDX_W-1:0];
    assign in_per   = TIME_WIDTH'(s_tdata[19:4]);
    assign in_cap   = TIME_WIDTH'(s_tdata[35:20]);

    // sequencer and sweep state
    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      iss_reg, iss_next;
    logic                  iss_on_reg, iss_on_next;
    logic                  dv_reg, dv_next;
    logic [IDX_W-1:0]      d_idx_reg, d_idx_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [TIME_WIDTH-1:0] best_per_reg, best_per_next;
    logic [TICK_MISS_W-1:0] miss_cnt_reg, miss_cnt_next;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // latched item
    logic [1:0]            op_reg, op_next;
    logic                  tab_reg, tab_next;
    logic                  nz_reg, nz_next;
    logic [TIME_WIDTH-1:0] per_reg, per_next;
    logic [TIME_WIDTH-1:0] cap_reg, cap_next;
    logic                  blk_reg, blk_next;

    // per-slot flags in flip-flops
    logic [TASK_SLOTS-1:0] active_reg, active_next;
    logic [TASK_SLOTS-1:0] blocked_reg, blocked_next;
    logic [TASK_SLOTS-1:0] written_reg, written_next;

    // result path
    logic [M_TDATA_W-1:0]  res_reg, res_next;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  out_free;

    // table port
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    ent_t                  mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    ent_t                  mem_rdata;
    ent_t                  ent;

    // slot unit
    alu_ctl_t              alu_ctl;
    logic                  alu_better;
    logic                  alu_hit;
    ent_t                  upd_ent;

    rmts_task_mem #(
        .DEPTH (TASK_SLOTS),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // an entry never written reads as its reset value
    assign ent = written_reg[d_idx_reg] ? mem_rdata : '0;

    assign alu_ctl.eligible   = active_reg[d_idx_reg] && !blocked_reg[d_idx_reg];
    assign alu_ctl.best_valid = (best_reg != '0);
    assign alu_ctl.charge     = (best_reg != '0) && (d_idx_reg == best_reg);
    assign upd_ent.period     = ent.period;
    assign upd_ent.capacity   = ent.capacity;

    rmts_slot_alu #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_alu (
        .ctl          (alu_ctl),
        .period       (ent.period),
        .capacity     (ent.capacity),
        .budget       (ent.budget),
        .deadline     (ent.deadline),
        .best_period  (best_per_reg),
        .miss         (ent.miss),
        .jobs         (ent.jobs),
        .better       (alu_better),
        .new_budget   (upd_ent.budget),
        .new_deadline (upd_ent.deadline),
        .new_miss     (upd_ent.miss),
        .new_jobs     (upd_ent.jobs),
        .miss_hit     (alu_hit)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        iss_next      = iss_reg;
        iss_on_next   = iss_on_reg;
        dv_next       = 1'b0;
        d_idx_next    = d_idx_reg;
        best_next     = best_reg;
        best_per_next = best_per_reg;
        miss_cnt_next = miss_cnt_reg;
        op_next       = op_reg;
        tab_next      = tab_reg;
        nz_next       = nz_reg;
        per_next      = per_reg;
        cap_next      = cap_reg;
        blk_next      = blk_reg;
        active_next   = active_reg;
        blocked_next  = blocked_reg;
        written_next  = written_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = d_idx_reg;
        mem_wdata     = upd_ent;
        mem_re        = 1'b0;
        mem_raddr     = iss_reg;

        // advance a running sweep by one slot
        if (iss_on_reg)
        begin
            mem_re      = 1'b1;
            mem_raddr   = iss_reg;
            dv_next     = 1'b1;
            d_idx_next  = iss_reg;
            iss_next    = IDX_W'(iss_reg + 1'b1);
            iss_on_next = (iss_reg != LAST_IDX);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next  = in_op;
                    tab_next = in_tab;
                    nz_next  = (in_slot != '0);
                    per_next = in_per;
                    cap_next = in_cap;
                    blk_next = s_tdata[36];
                    if (in_op == OP_TICK)
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = FIRST_IDX;
                        dv_next       = 1'b1;
                        d_idx_next    = FIRST_IDX;
                        iss_next      = SECOND_IDX;
                        iss_on_next   = (TASK_SLOTS > 2);
                        best_next     = '0;
                        miss_cnt_next = '0;
                        state_next    = S_PICK;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = in_idx;
                        dv_next    = 1'b1;
                        d_idx_next = in_idx;
                        state_next = S_APPLY;
                    end
                end
            end
            S_PICK:
            begin
                if (dv_reg)
                begin
                    if (alu_better)
                    begin
                        best_next     = d_idx_reg;
                        best_per_next = ent.period;
                    end
                    // start the update sweep right behind the pick sweep
                    if (d_idx_reg == LAST_IDX)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = FIRST_IDX;
                        dv_next     = 1'b1;
                        d_idx_next  = FIRST_IDX;
                        iss_next    = SECOND_IDX;
                        iss_on_next = (TASK_SLOTS > 2);
                        state_next  = S_UPDT;
                    end
                end
            end
            S_UPDT:
            begin
                if (dv_reg)
                begin
                    if (active_reg[d_idx_reg])
                    begin
                        mem_we = 1'b1;
                        if (alu_hit)
                        begin
                            miss_cnt_next = TICK_MISS_W'(miss_cnt_reg + 1'b1);
                        end
                    end
                    if (d_idx_reg == LAST_IDX)
                    begin
                        res_next = M_TDATA_W'({
                            (active_reg[d_idx_reg] && alu_hit)
                                ? TICK_MISS_W'(miss_cnt_reg + 1'b1) : miss_cnt_reg,
                            SLOT_W'(best_reg)});
                        state_next = S_PUSH;
                    end
                end
            end
            S_APPLY:
            begin
                res_next = '0;
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (tab_reg && nz_reg)
                        begin
                            mem_we                  = 1'b1;
                            written_next[d_idx_reg] = 1'b1;
                            if (per_reg == '0)
                            begin
                                // drop from the set, keep the counters
                                active_next[d_idx_reg] = 1'b0;
                                mem_wdata      = '0;
                                mem_wdata.miss = ent.miss;
                                mem_wdata.jobs = ent.jobs;
                            end
                            else
                            begin
                                active_next[d_idx_reg] = 1'b1;
                                mem_wdata.period   = per_reg;
                                mem_wdata.capacity = cap_reg;
                                mem_wdata.budget   = cap_reg;
                                mem_wdata.deadline = per_reg;
                                mem_wdata.miss     = '0;
                                mem_wdata.jobs     = '0;
                            end
                        end
                    end
                    OP_BLOCK:
                    begin
                        if (tab_reg && nz_reg)
                        begin
                            blocked_next[d_idx_reg] = blk_reg;
                        end
                    end
                    OP_READ:
                    begin
                        if (tab_reg)
                        begin
                            res_next = M_TDATA_W'({
                                FIELD_W'(ent.deadline),
                                FIELD_W'(ent.budget),
                                ent.jobs,
                                ent.miss,
                                TICK_MISS_W'(0),
                                SLOT_W'(0)});
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            iss_reg     <= '0;
            iss_on_reg  <= 1'b0;
            dv_reg      <= 1'b0;
            d_idx_reg   <= '0;
            active_reg  <= '0;
            blocked_reg <= '0;
            written_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            iss_reg     <= iss_next;
            iss_on_reg  <= iss_on_next;
            dv_reg      <= dv_next;
            d_idx_reg   <= d_idx_next;
            active_reg  <= active_next;
            blocked_reg <= blocked_next;
            written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_per_reg <= best_per_next;
        miss_cnt_reg <= miss_cnt_next;
        op_reg       <= op_next;
        tab_reg      <= tab_next;
        nz_reg       <= nz_next;
        per_reg      <= per_next;
        cap_reg      <= cap_next;
        blk_reg      <= blk_next;
        res_reg      <= res_next;
    end

    // output register: hold a result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == S_PUSH) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PUSH) && out_free)
        begin
            m_tdata_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // the idle slot is never written
    a_no_slot0_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr != '0))
        else $error("table write to idle slot");

    // a sweep never writes the entry it is reading
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read and write at one address");

    // one item at a time: accept drops ready on the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("second item taken while busy");

    // the picked task stays active through the update sweep
    a_best_active: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPDT) && (best_reg != '0)) |-> active_reg[best_reg])
        else $error("picked task not active");
`endif

endmodule

`default_nettype wire
